// File: hw/rtl/integral_image_sum_and_square_unit_assert.svh
// Assertion macros shared by the integral image RTL.
// No dependencies; the files that check their logic include this header.
`ifndef INTEGRAL_IMAGE_SUM_AND_SQUARE_UNIT_ASSERT_SVH
`define INTEGRAL_IMAGE_SUM_AND_SQUARE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define IISQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("iisq: assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define IISQ_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("iisq: forbidden condition seen");

`else

`define IISQ_ASSERT(lbl, clk, rstn, prop)
`define IISQ_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: hw/rtl/iisq_pkg.sv
// Shared widths, register indexes, reset values and types of the integral image unit.
// No dependencies.
`default_nettype none

package iisq_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 28;
  localparam int SQ_W      = 36;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Per-item control that travels from the front stage to the combine stage.
  typedef struct packed {
    logic row_nz;     // pixel is not in the first row; previous row term applies
    logic frame_last; // pixel closes the frame
  } iisq_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/integral_image_sum_and_square_unit.sv
// Top level of the integral image unit (sum and square sum per pixel).
// Uses iisq_pkg, iisq_front, iisq_line_store and the assertion macro header.
//
// Usage: grey pixels arrive in raster order on the slave stream, one per beat
// (s_axis_tdata_i[7:0]). For every pixel the master stream delivers one beat with
// the integral of pixels and of squared pixels from the frame origin to that pixel;
// tlast marks the last pixel of a frame. Frame width and height are set through a
// plain write port (index 0: width, index 1: height) while the stream is idle.
// The result beat passes from the combine stage into the output register before it is valid.
// Throughput is one pixel per cycle while the output is not stalled: the line store is
// read when a pixel enters and written back when that pixel leaves the combine stage,
// with a write-to-read bypass for the single-column case. A result waiting in the
// output register does not block the next pixel; only when both the combine stage
// and the output register are full and m_axis_tready_i is low does s_axis_tready_o
// drop. Reset clears counters, row sums and valid flags and restores the default
// 640 x 480 frame; the line store is not cleared, since the first row of each frame
// never uses what it reads from it.
`default_nettype none

`include "integral_image_sum_and_square_unit_assert.svh"

module integral_image_sum_and_square_unit
  import iisq_pkg::*;
#(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] pixel
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [63:0]          m_axis_tdata_o,   // [27:0] area_sum, [63:28] area_square_sum
  output logic                      m_axis_tlast_o    // frame_end
);

  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowSumW = PIX_W + ColW;
  localparam int RowSqW  = 2 * PIX_W + ColW;

  logic               accept;
  logic               s1_adv;
  logic               s1_v_q;
  logic [ColW-1:0]    rd_addr;
  logic [ColW-1:0]    s1_col;
  logic [RowSumW-1:0] s1_row_sum;
  logic [RowSqW-1:0]  s1_row_sq;
  iisq_ctl_t          s1_ctl;
  logic [SUM_W-1:0]   prev_sum;
  logic [SQ_W-1:0]    prev_sq;
  logic [SUM_W-1:0]   area_sum;
  logic [SQ_W-1:0]    area_sq;

  logic               out_v_q;
  logic [SUM_W-1:0]   out_sum_q;
  logic [SQ_W-1:0]    out_sq_q;
  logic               out_last_q;

  // The combine stage moves on whenever the output register is empty or being drained.
  assign s1_adv          = s1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_v_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  iisq_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .pixel_i      (s_axis_tdata_i[PIX_W-1:0]),
    .rd_addr_o    (rd_addr),
    .s1_col_o     (s1_col),
    .s1_row_sum_o (s1_row_sum),
    .s1_row_sq_o  (s1_row_sq),
    .s1_ctl_o     (s1_ctl)
  );

  iisq_line_store #(
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col),
    .wr_sum_i  (area_sum),
    .wr_sq_i   (area_sq),
    .rd_sum_o  (prev_sum),
    .rd_sq_o   (prev_sq)
  );

  // The first row of a frame has no previous-row term. Sums wrap at the field width.
  always_comb begin
    area_sum = SUM_W'(s1_row_sum);
    area_sq  = SQ_W'(s1_row_sq);
    if (s1_ctl.row_nz) begin
      area_sum = SUM_W'(s1_row_sum) + prev_sum;
      area_sq  = SQ_W'(s1_row_sq) + prev_sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sum_q  <= area_sum;
      out_sq_q   <= area_sq;
      out_last_q <= s1_ctl.frame_last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_sq_q, out_sum_q};
  assign m_axis_tlast_o  = out_last_q;

  // An accepted pixel always lands in the combine stage.
  `IISQ_ASSERT(a_accept_fills_s1, clk_i, rst_ni, accept |=> s1_v_q)
  // A pixel never enters while the combine stage holds one that cannot leave.
  `IISQ_NEVER(a_no_overwrite, clk_i, rst_ni, accept && s1_v_q && !s1_adv)
  // A stalled combine stage keeps its pixel.
  `IISQ_ASSERT(a_stall_holds, clk_i, rst_ni, (s1_v_q && !s1_adv) |=> s1_v_q)
  // A pixel leaving the combine stage always shows up as a result.
  `IISQ_ASSERT(a_adv_to_out, clk_i, rst_ni, s1_adv |=> out_v_q)

endmodule

`default_nettype wire

// File: hw/rtl/iisq_line_store.sv
// Line store holding the previous row's sum and square-sum integrals.
// Uses iisq_pkg; one write port and one registered read port with write forwarding.
`default_nettype none

module iisq_line_store
  import iisq_pkg::*;
#(
  parameter int Depth = MAX_WIDTH_DEF,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [SUM_W-1:0] wr_sum_i,
  input  wire logic [SQ_W-1:0]  wr_sq_i,
  output logic      [SUM_W-1:0] rd_sum_o,
  output logic      [SQ_W-1:0]  rd_sq_o
);

  logic [SUM_W-1:0] sum_mem [Depth];
  logic [SQ_W-1:0]  sq_mem  [Depth];

  logic [SUM_W-1:0] rd_sum_q;
  logic [SQ_W-1:0]  rd_sq_q;
  logic [SUM_W-1:0] fwd_sum_q;
  logic [SQ_W-1:0]  fwd_sq_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sum_mem[wr_addr_i] <= wr_sum_i;
      sq_mem[wr_addr_i]  <= wr_sq_i;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_sum_q  <= sum_mem[rd_addr_i];
      rd_sq_q   <= sq_mem[rd_addr_i];
      fwd_q     <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_sum_q <= wr_sum_i;
      fwd_sq_q  <= wr_sq_i;
    end
  end

  assign rd_sum_o = fwd_q ? fwd_sum_q : rd_sum_q;
  assign rd_sq_o  = fwd_q ? fwd_sq_q  : rd_sq_q;

endmodule

`default_nettype wire

// File: hw/rtl/iisq_front.sv
// Front stage: configuration registers, raster counters and running row sums.
// Uses iisq_pkg; feeds the line store read address and the combine stage.
`default_nettype none

module iisq_front
  import iisq_pkg::*;
#(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF,
  localparam int ColW    = $clog2(MaxWidth),
  localparam int RowW    = $clog2(MaxHeight),
  localparam int RowSumW = PIX_W + ColW,
  localparam int RowSqW  = 2 * PIX_W + ColW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 accept_i,
  input  wire logic [PIX_W-1:0]     pixel_i,
  output logic      [ColW-1:0]      rd_addr_o,
  output logic      [ColW-1:0]      s1_col_o,
  output logic      [RowSumW-1:0]   s1_row_sum_o,
  output logic      [RowSqW-1:0]    s1_row_sq_o,
  output iisq_ctl_t                 s1_ctl_o
);

  localparam int WCmpW = (CFG_W > ColW + 1) ? CFG_W : ColW + 1;
  localparam int HCmpW = (CFG_W > RowW + 1) ? CFG_W : RowW + 1;

  logic [CFG_W-1:0]   frame_width_q, frame_height_q;
  logic [ColW-1:0]    col_cnt_q, col_cnt_d;
  logic [RowW-1:0]    row_cnt_q, row_cnt_d;
  logic [RowSumW-1:0] row_sum_q, row_sum_d;
  logic [RowSqW-1:0]  row_sq_q, row_sq_d;
  logic [ColW-1:0]    s1_col_q;
  iisq_ctl_t          s1_ctl_q, s1_ctl_d;

  logic [WCmpW-1:0]   width_eff, col_next;
  logic [HCmpW-1:0]   height_eff, row_next;
  logic [2*PIX_W-1:0] pix_sq;

  // Out-of-range frame sizes: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = WCmpW'(1);
    end else if (WCmpW'(frame_width_q) > WCmpW'(MaxWidth)) begin
      width_eff = WCmpW'(MaxWidth);
    end else begin
      width_eff = WCmpW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_eff = HCmpW'(1);
    end else if (HCmpW'(frame_height_q) > HCmpW'(MaxHeight)) begin
      height_eff = HCmpW'(MaxHeight);
    end else begin
      height_eff = HCmpW'(frame_height_q);
    end
  end

  always_comb begin
    col_next = WCmpW'(col_cnt_q) + WCmpW'(1);
    row_next = HCmpW'(row_cnt_q) + HCmpW'(1);
    pix_sq   = (2 * PIX_W)'(pixel_i) * (2 * PIX_W)'(pixel_i);

    s1_ctl_d.row_nz     = (row_cnt_q != '0);
    s1_ctl_d.frame_last = 1'b0;
    col_cnt_d           = col_cnt_q + ColW'(1);
    row_cnt_d           = row_cnt_q;
    if (col_next >= width_eff) begin
      col_cnt_d = '0;
      if (row_next >= height_eff) begin
        row_cnt_d           = '0;
        s1_ctl_d.frame_last = 1'b1;
      end else begin
        row_cnt_d = row_cnt_q + RowW'(1);
      end
    end

    if (col_cnt_q == '0) begin
      row_sum_d = RowSumW'(pixel_i);
      row_sq_d  = RowSqW'(pix_sq);
    end else begin
      row_sum_d = row_sum_q + RowSumW'(pixel_i);
      row_sq_d  = row_sq_q + RowSqW'(pix_sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      col_cnt_q      <= '0;
      row_cnt_q      <= '0;
      row_sum_q      <= '0;
      row_sq_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
        row_sum_q <= row_sum_d;
        row_sq_q  <= row_sq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_col_q <= col_cnt_q;
      s1_ctl_q <= s1_ctl_d;
    end
  end

  assign rd_addr_o    = col_cnt_q;
  assign s1_col_o     = s1_col_q;
  assign s1_row_sum_o = row_sum_q;
  assign s1_row_sq_o  = row_sq_q;
  assign s1_ctl_o     = s1_ctl_q;

endmodule

`default_nettype wire
